// ----- rtl/core/msf_pkg.sv -----
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types, constants and a helper function of the mean-shift color filter.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MAX_RADIUS_DEF = 16;
  localparam int MAX_STEPS_DEF  = 5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BW_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  // 0.09 in Q16, scaled by 100.
  localparam logic [39:0] TOL_NUM = 40'd589824;

  // Color components in Q8 Lab units fit 17 bits signed.
  localparam int CW = 17;
  // Sums over at most 128x128 window pixels.
  localparam int SW = 40;
  // Divider width (dividend magnitude bits).
  localparam int DW = 40;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_start;   // latch the start pixel color from read data
    logic clear_sums;   // clear accumulators at start of a pass
    logic accum;        // accumulate the read pixel at the given position
    logic div_start;    // start dividing the sums
    logic finish_step;  // commit divided means and evaluate shift
  } msf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic keep_going;   // both shifts exceed the tolerance
  } msf_sts_t;

  // floor(L * 25600 / 255) for an 8-bit L. With y = 100 * L this is
  // y + floor(y / 255), and y / 255 is taken by a reciprocal multiply that
  // is exact for y up to 25500.
  function automatic logic [15:0] l_to_q(input logic [7:0] l);
    logic [14:0] y;
    logic [30:0] r;
    y = 15'(l) * 15'd100;
    r = 31'(y) * 31'd32897;
    return 16'(y) + 16'(r[30:23]);
  endfunction

endpackage

// ----- rtl/core/msf_ram.sv -----
// ----------------------------------------------------------------------------
// msf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module msf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/msf_div.sv -----
// ----------------------------------------------------------------------------
// msf_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module msf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [msf_pkg::SW-1:0] dividend,
  input  logic [14:0]              divisor,
  output logic                     busy,
  output logic signed [msf_pkg::SW-1:0] quotient
);

  localparam int DW = msf_pkg::DW;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [14:0]   den_r;
  logic          neg_r;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r;
  logic [DW:0]   trial;

  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    rem_nxt = trial[DW-1:0];
    quo_nxt = {quo_r[DW-2:0], 1'b0};
    if (trial >= {{(DW-14){1'b0}}, den_r}) begin
      rem_nxt    = DW'(trial - {{(DW-14){1'b0}}, den_r});
      quo_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(DW);
      rem_r  <= '0;
      quo_r  <= dividend[DW-1] ? DW'(-dividend) : dividend;
      neg_r  <= dividend[DW-1];
      den_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

// ----- rtl/core/msf_datapath.sv -----
// ----------------------------------------------------------------------------
// msf_datapath
// Means, window accumulators, divider, shift test and output mapping.
// ----------------------------------------------------------------------------
module msf_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msf_pkg::msf_cmd_t    cmd,
  output msf_pkg::msf_sts_t    sts,
  input  logic [23:0]          rdata,
  input  logic [8:0]           start_row,
  input  logic [8:0]           start_col,
  input  logic [15:0]          bw_sq,
  input  logic [11:0]          pix_row,
  input  logic [11:0]          pix_col,
  output logic [7:0]           res_l,
  output logic [7:0]           res_a,
  output logic [7:0]           res_b
);

  localparam int SW = msf_pkg::SW;

  logic signed [17:0] my_r, mx_r, ml_r, ma_r, mb_r;
  logic signed [17:0] py_r, px_r, pl_r, pa_r, pb_r;
  logic signed [SW-1:0] sy_r, sx_r, sl_r, sa_r, sb_r;
  logic [14:0] n_r;
  logic [2:0]  dsel_r;
  logic        div_go_r;
  logic signed [17:0] q_r [5];

  // Pixel color in Q8.
  logic signed [17:0] pl, pa, pb;
  logic signed [18:0] dl, da, db;
  logic signed [37:0] sq_dl, sq_da, sq_db;
  logic signed [37:0] sq_cl, sq_ca, sq_cb, sq_cy, sq_cx;
  logic [39:0] pdist, cdist, sdist;
  logic signed [18:0] cl, ca, cb, cy, cx;

  always_comb begin
    pl = $signed({2'b00, msf_pkg::l_to_q(rdata[23:16])});
    pa = $signed({2'b00, rdata[15:8], 8'd0}) - 18'sd32768;
    pb = $signed({2'b00, rdata[7:0], 8'd0}) - 18'sd32768;
    dl = 19'(pl) - 19'(ml_r);
    da = 19'(pa) - 19'(ma_r);
    db = 19'(pb) - 19'(mb_r);
    sq_dl = dl * dl;
    sq_da = da * da;
    sq_db = db * db;
    pdist = 40'(sq_dl) + 40'(sq_da) + 40'(sq_db);
    cl = 19'(ml_r) - 19'(pl_r);
    ca = 19'(ma_r) - 19'(pa_r);
    cb = 19'(mb_r) - 19'(pb_r);
    cy = 19'(my_r) - 19'(py_r);
    cx = 19'(mx_r) - 19'(px_r);
    sq_cl = cl * cl;
    sq_ca = ca * ca;
    sq_cb = cb * cb;
    sq_cy = cy * cy;
    sq_cx = cx * cx;
    cdist = 40'(sq_cl) + 40'(sq_ca) + 40'(sq_cb);
    sdist = 40'(sq_cy) + 40'(sq_cx);
  end

  logic div_start, div_busy;
  logic signed [SW-1:0] div_in, div_q;

  always_comb begin
    case (dsel_r)
      3'd0: div_in = sy_r;
      3'd1: div_in = sx_r;
      3'd2: div_in = sl_r;
      3'd3: div_in = sa_r;
      default: div_in = sb_r;
    endcase
  end

  assign div_start = cmd.div_start || div_go_r;

  msf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_in),
    .divisor(n_r), .busy(div_busy), .quotient(div_q)
  );

  logic done_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsel_r      <= '0;
      div_go_r    <= 1'b0;
      done_seen_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (cmd.div_start) begin
        dsel_r      <= '0;
        done_seen_r <= 1'b1;
      end else if (done_seen_r && !div_busy && !div_go_r) begin
        q_r[dsel_r] <= 18'(div_q);
        if (dsel_r == 3'd4) begin
          // Back to the first sum so that the next step starts with it.
          dsel_r      <= '0;
          done_seen_r <= 1'b0;
        end else begin
          dsel_r   <= dsel_r + 3'd1;
          div_go_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      my_r <= $signed({1'b0, start_row, 8'd0});
      mx_r <= $signed({1'b0, start_col, 8'd0});
      ml_r <= pl;
      ma_r <= pa;
      mb_r <= pb;
    end
    if (cmd.clear_sums) begin
      sy_r <= '0; sx_r <= '0; sl_r <= '0; sa_r <= '0; sb_r <= '0;
      n_r  <= '0;
      py_r <= my_r; px_r <= mx_r; pl_r <= ml_r; pa_r <= ma_r; pb_r <= mb_r;
    end
    if (cmd.accum && pdist < {8'd0, bw_sq, 16'd0}) begin
      sy_r <= sy_r + SW'({pix_row, 8'd0});
      sx_r <= sx_r + SW'({pix_col, 8'd0});
      sl_r <= sl_r + SW'(pl);
      sa_r <= sa_r + SW'(pa);
      sb_r <= sb_r + SW'(pb);
      n_r  <= n_r + 15'd1;
    end
    if (cmd.finish_step && n_r != '0) begin
      my_r <= q_r[0]; mx_r <= q_r[1]; ml_r <= q_r[2];
      ma_r <= q_r[3]; mb_r <= q_r[4];
    end
  end

  // L * 255 / 25600 is taken as (L * 255 / 256) / 100, the last step by a
  // reciprocal multiply that is exact up to 25500.
  logic [22:0] l255;
  logic [27:0] l_rec;
  logic [8:0]  lo;
  logic signed [18:0] ao, bo;

  always_comb begin
    sts.div_busy   = div_busy || div_go_r || done_seen_r;
    sts.keep_going = (48'(cdist) * 48'd100 > 48'(msf_pkg::TOL_NUM)) &&
                     (48'(sdist) * 48'd100 > 48'(msf_pkg::TOL_NUM));
    l255  = 23'(ml_r[14:0]) * 23'd255;
    l_rec = 28'(l255[22:8]) * 28'd5243;
    lo    = l_rec[27:19];
    ao = 19'(ma_r) + 19'sd32768;
    bo = 19'(mb_r) + 19'sd32768;
    res_l = ml_r[17] ? 8'd0 :
            ((ml_r[16:15] != 2'b00 || lo > 9'd255) ? 8'd255 : lo[7:0]);
    res_a = ao[18] ? 8'd0 : (ao[17:16] != 2'b00 ? 8'd255 : ao[15:8]);
    res_b = bo[18] ? 8'd0 : (bo[17:16] != 2'b00 ? 8'd255 : bo[15:8]);
  end

endmodule

// ----- rtl/core/msf_ctrl.sv -----
// ----------------------------------------------------------------------------
// msf_ctrl
// Sequencer: start read, window scan passes, division and output.
// ----------------------------------------------------------------------------
module msf_ctrl #(
  parameter int MAX_STEPS = msf_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              win_empty,
  input  logic              scan_last,
  input  msf_pkg::msf_sts_t sts,
  input  logic              out_free,
  output msf_pkg::msf_cmd_t cmd,
  output logic              idle,
  output logic              scan_en,
  output logic              scan_rst,
  output logic              emit,
  output logic [2:0]        steps
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] steps_r, steps_nxt;
  logic [1:0] drain_r;
  logic       acc_d_r;

  always_comb begin
    state_nxt = state_r;
    steps_nxt = steps_r;
    cmd       = '0;
    scan_en   = 1'b0;
    scan_rst  = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_START;
      S_START: begin
        // The start pixel is on the read data only in this cycle.
        cmd.load_start = 1'b1;
        state_nxt      = S_LOAD;
      end
      S_LOAD: begin
        cmd.clear_sums = 1'b1;
        scan_rst       = 1'b1;
        steps_nxt      = '0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (win_empty) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_en = 1'b1;
          if (scan_last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_r == 2'd1) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.finish_step = 1'b1;
          steps_nxt       = steps_r + 5'd1;
          state_nxt       = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.keep_going && steps_r < 5'(MAX_STEPS)) begin
          cmd.clear_sums = 1'b1;
          scan_rst       = 1'b1;
          state_nxt      = S_SCAN;
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // Accumulate stage sees read data in the cycle after its address.
    cmd.accum = acc_d_r && (state_r == S_SCAN || state_r == S_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      steps_r <= '0;
      drain_r <= '0;
      acc_d_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      acc_d_r <= scan_en;
      drain_r <= (state_r == S_DRAIN) ? drain_r + 2'd1 : 2'd0;
    end
  end

  assign idle  = (state_r == S_IDLE);
  assign steps = steps_r[2:0];

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> state_r == S_IDLE) else $error("emit did not return to idle");
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= 5'(MAX_STEPS)) else $error("step count overflow");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |-> $past(state_r == S_IDLE))
    else $error("start out of idle");

endmodule

// ----- rtl/core/mean_shift_color_filter_core.sv -----
// ----------------------------------------------------------------------------
// mean_shift_color_filter_core
// Frame store with per-pixel mean-shift color filtering.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in_     | input     | in_tvalid/in_tready, cmd in in_tuser
// out_    | output    | out_tvalid/out_tready, registered
// cfg_    | input     | cfg_valid/cfg_ready, always ready
//
// In a filter request the window scan reads the frame store one pixel per
// cycle and the five means use a bit-serial divider.
// Reset is synchronous; the frame store is not cleared. A finished result
// waits in the output register while the next request is accepted.
module mean_shift_color_filter_core #(
  parameter int MAX_WIDTH  = msf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = msf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = msf_pkg::MAX_RADIUS_DEF,
  parameter int MAX_STEPS  = msf_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pixel_row, pixel_col, in_l, in_a, in_b, pad
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_l, out_a, out_b, steps_used, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [4:0]  radius_r;
  logic [15:0] bw_r;
  logic [9:0]  width_r, height_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 5'd8; bw_r <= 16'd64; width_r <= 10'd512; height_r <= 10'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        msf_pkg::REG_RADIUS: radius_r <= cfg_data[4:0];
        msf_pkg::REG_BW_SQ:  bw_r     <= cfg_data;
        msf_pkg::REG_WIDTH:  width_r  <= cfg_data[9:0];
        msf_pkg::REG_HEIGHT: height_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic [8:0] row_r, col_r;
  logic       idle, start, emit, scan_en, scan_rst;
  logic [2:0] steps;
  logic       out_v_r;
  logic       out_free;
  msf_pkg::msf_cmd_t cmd;
  msf_pkg::msf_sts_t sts;

  assign in_tready = idle;
  assign start     = in_tvalid && idle && in_tuser == msf_pkg::CMD_FILTER;
  assign out_free  = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      row_r <= in_tdata[8:0];
      col_r <= in_tdata[17:9];
    end
  end

  // Window bounds, 14-bit signed to cover row +- radius.
  logic signed [13:0] rad, top, bot, lft, rgt, hcap, wcap;
  logic signed [13:0] hy_r, hx_r;
  always_comb begin
    rad  = (14'(radius_r) > 14'(MAX_RADIUS)) ? 14'(MAX_RADIUS) : 14'(radius_r);
    hcap = (14'(height_r) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(height_r);
    wcap = (14'(width_r) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(width_r);
    top  = $signed(14'(row_r)) - rad; if (top < 0) top = '0;
    bot  = $signed(14'(row_r)) + rad; if (bot > hcap) bot = hcap;
    lft  = $signed(14'(col_r)) - rad; if (lft < 0) lft = '0;
    rgt  = $signed(14'(col_r)) + rad; if (rgt > wcap) rgt = wcap;
  end

  logic win_empty, scan_last;
  assign win_empty = (top >= bot) || (lft >= rgt);
  assign scan_last = (hx_r == rgt - 14'sd1) && (hy_r == bot - 14'sd1);

  logic [11:0] pix_row_r, pix_col_r;
  always_ff @(posedge clk) begin
    if (scan_rst) begin
      hy_r <= top; hx_r <= lft;
    end else if (scan_en) begin
      if (hx_r == rgt - 14'sd1) begin
        hx_r <= lft; hy_r <= hy_r + 14'sd1;
      end else begin
        hx_r <= hx_r + 14'sd1;
      end
    end
    pix_row_r <= 12'(hy_r);
    pix_col_r <= 12'(hx_r);
  end

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   rdata;
  assign we    = in_tvalid && idle && in_tuser == msf_pkg::CMD_WRITE;
  assign waddr = AW'((32'(in_tdata[8:0]) % MAX_HEIGHT) * MAX_WIDTH
                     + 32'(in_tdata[17:9]) % MAX_WIDTH);
  always_comb begin
    if (idle) begin
      raddr = waddr;
    end else begin
      raddr = AW'(32'(hy_r) * MAX_WIDTH + 32'(hx_r));
    end
  end

  msf_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({in_tdata[25:18], in_tdata[33:26], in_tdata[41:34]}),
    .raddr(raddr), .rdata(rdata)
  );

  msf_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .win_empty(win_empty),
    .scan_last(scan_last), .sts(sts), .out_free(out_free), .cmd(cmd),
    .idle(idle), .scan_en(scan_en), .scan_rst(scan_rst), .emit(emit),
    .steps(steps)
  );

  logic [7:0] res_l, res_a, res_b;
  msf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .rdata(rdata),
    .start_row(row_r), .start_col(col_r), .bw_sq(bw_r),
    .pix_row(pix_row_r), .pix_col(pix_col_r),
    .res_l(res_l), .res_a(res_a), .res_b(res_b)
  );

  logic [26:0] out_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (emit) out_d_r <= {steps, res_b, res_a, res_l};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_d_r};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r) else $error("result dropped");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_v_r || out_tready)) else $error("result overwritten");
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> idle) else $error("write while busy");

endmodule
